@@ rtl/core/satlb_pkg.sv @@
// satlb_pkg: shared constants, operation and status codes, update struct
// for the set-associative tlb with lru ranks
// no dependencies
package satlb_pkg;

    // default geometry
    localparam int SETS_DEF             = 16;
    localparam int WAYS_DEF             = 4;
    localparam int PAGE_OFFSET_BITS_DEF = 12;
    localparam int VA_BITS_DEF          = 48;

    // physical address width is fixed
    localparam int PA_BITS = 48;

    // request codes
    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_FILL      = 2'd1,
        OP_PEEK      = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    // result codes
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_FILLED  = 3'd2,
        ST_FAULT   = 3'd3,
        ST_PEEKED  = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    // state update issued by the lookup for the set in flight
    typedef struct packed {
        logic row_we;
        logic clear_all;
    } t_upd;

endpackage

@@ rtl/core/satlb_lookup.sv @@
// satlb_lookup: parallel way compare, victim choice and lru rank update
// for one set; pure combinational
// depends on satlb_pkg
module satlb_lookup #(
    parameter int WAYS   = satlb_pkg::WAYS_DEF,
    parameter int TAG_W  = 32,
    parameter int POB    = satlb_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int PB_W   = satlb_pkg::PA_BITS - POB,
    parameter int RANK_W = $clog2(WAYS + 1)
) (
    input  satlb_pkg::t_op                  i_op,
    input  logic                            i_fault,
    input  logic [TAG_W-1:0]                i_tag,
    input  logic [POB-1:0]                  i_offset,
    input  logic [satlb_pkg::PA_BITS-1:0]   i_walk_base,
    input  logic [WAYS-1:0]                 i_valid,
    input  logic [WAYS-1:0][TAG_W-1:0]      i_tags,
    input  logic [WAYS-1:0][PB_W-1:0]       i_bases,
    input  logic [WAYS-1:0][RANK_W-1:0]     i_ranks,
    output satlb_pkg::t_status              o_status,
    output logic [satlb_pkg::PA_BITS-1:0]   o_phys,
    output logic [RANK_W-1:0]               o_rank,
    output satlb_pkg::t_upd                 o_upd,
    output logic [WAYS-1:0]                 o_valid_set,
    output logic [WAYS-1:0][TAG_W-1:0]      o_tags,
    output logic [WAYS-1:0][PB_W-1:0]       o_bases,
    output logic [WAYS-1:0][RANK_W-1:0]     o_ranks
);

    localparam int WAY_W = $clog2(WAYS);

    logic [WAYS-1:0]   hit_vec;
    logic              hit_any;
    logic [WAY_W-1:0]  hit_idx;
    logic              inv_any;
    logic [WAY_W-1:0]  inv_idx;
    logic [WAY_W-1:0]  lru_idx;
    logic [WAY_W-1:0]  tgt;
    logic [RANK_W-1:0] old_rank;
    logic              promote;
    logic              install;

    // tag compare and priority picks, lowest way wins
    always_comb begin
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = i_valid[w] && (i_tags[w] == i_tag);
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                inv_idx = WAY_W'(w);
            end
            // in a full set the ranks are distinct, so the oldest holds rank WAYS
            if (i_ranks[w] == RANK_W'(WAYS)) begin
                lru_idx = WAY_W'(w);
            end
        end
        hit_any = |hit_vec;
        inv_any = ~&i_valid;
        tgt     = hit_any ? hit_idx : (inv_any ? inv_idx : lru_idx);
    end

    // decode of the request
    always_comb begin
        o_status = satlb_pkg::ST_MISS;
        o_phys   = '0;
        o_rank   = '0;
        o_upd    = '0;
        promote  = 1'b0;
        install  = 1'b0;
        case (i_op)
            satlb_pkg::OP_TRANSLATE: begin
                if (hit_any) begin
                    o_status = satlb_pkg::ST_HIT;
                    o_phys   = {i_bases[hit_idx], i_offset};
                    promote  = 1'b1;
                end else begin
                    o_status = satlb_pkg::ST_MISS;
                end
            end
            satlb_pkg::OP_FILL: begin
                if (i_fault) begin
                    o_status = satlb_pkg::ST_FAULT;
                end else begin
                    o_status = satlb_pkg::ST_FILLED;
                    o_phys   = {i_walk_base[satlb_pkg::PA_BITS-1:POB], i_offset};
                    promote  = 1'b1;
                    install  = 1'b1;
                end
            end
            satlb_pkg::OP_PEEK: begin
                o_status = satlb_pkg::ST_PEEKED;
                o_rank   = hit_any ? i_ranks[hit_idx] : '0;
            end
            satlb_pkg::OP_CLEAR: begin
                o_status        = satlb_pkg::ST_CLEARED;
                o_upd.clear_all = 1'b1;
            end
            default: begin
                o_status = satlb_pkg::ST_MISS;
            end
        endcase
        o_upd.row_we = promote;
    end

    // new row contents: target becomes most recent, younger valid ways age
    always_comb begin
        old_rank    = i_valid[tgt] ? i_ranks[tgt] : '0;
        o_tags      = i_tags;
        o_bases     = i_bases;
        o_valid_set = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) == tgt) begin
                o_ranks[i] = RANK_W'(1);
            end else if (i_valid[i] && (old_rank == '0 || i_ranks[i] < old_rank)) begin
                o_ranks[i] = i_ranks[i] + RANK_W'(1);
            end else begin
                o_ranks[i] = i_ranks[i];
            end
        end
        if (install) begin
            o_tags[tgt]      = i_tag;
            o_bases[tgt]     = i_walk_base[satlb_pkg::PA_BITS-1:POB];
            o_valid_set[tgt] = 1'b1;
        end
    end

endmodule

@@ rtl/core/satlb_store.sv @@
// satlb_store: per-set row memory with registered read and write forwarding,
// plus valid flops cleared at reset and by a clear request
// depends on satlb_pkg
module satlb_store #(
    parameter int SETS  = satlb_pkg::SETS_DEF,
    parameter int WAYS  = satlb_pkg::WAYS_DEF,
    parameter int ROW_W = 284,
    parameter int SET_W = $clog2(SETS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SET_W-1:0]  i_rd_set,
    input  satlb_pkg::t_upd   i_wr,
    input  logic [SET_W-1:0]  i_wr_set,
    input  logic [WAYS-1:0]   i_valid_set,
    input  logic [ROW_W-1:0]  i_wr_row,
    output logic [ROW_W-1:0]  o_row,
    output logic [WAYS-1:0]   o_valid
);

    logic [ROW_W-1:0]            r_mem [SETS];
    logic [ROW_W-1:0]            r_rd_row;
    logic [ROW_W-1:0]            r_fwd_row;
    logic                        r_fwd;
    logic [SETS-1:0][WAYS-1:0]   r_valid;
    logic [SETS-1:0][WAYS-1:0]   n_valid;

    // row memory, read-before-write
    always_ff @(posedge i_clk) begin
        if (i_wr.row_we) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row  <= r_mem[i_rd_set];
            r_fwd_row <= i_wr_row;
        end
    end

    // forward a row written in the same cycle it is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr.row_we && (i_wr_set == i_rd_set);
        end
    end

    assign o_row = r_fwd ? r_fwd_row : r_rd_row;

    // valid bits
    always_comb begin
        n_valid = r_valid;
        if (i_wr.clear_all) begin
            n_valid = '0;
        end else if (i_wr.row_we) begin
            n_valid[i_wr_set] = r_valid[i_wr_set] | i_valid_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid[i_wr_set];

endmodule

@@ rtl/core/set_assoc_tlb_lru_top.sv @@
// set_assoc_tlb_lru_top: set-associative tlb with exact lru ranks per set
// depends on satlb_pkg, satlb_store, satlb_lookup
//
//  channel  | valid      | ready      | payload
//  ---------+------------+------------+------------------------------------------
//  request  | i_in_valid | o_in_ready | i_op i_virt_addr i_walk_page_base i_walk_fault
//  result   | o_out_valid| i_out_ready| o_status o_phys_addr o_lru_rank
//
// one item per cycle while results are taken; after its item is taken, a result passes
// the input register (row read alongside) and then the lookup into the result register
// an item that follows one to the same set gets the updated row by forwarding
// reset clears the valid bits at once, so no clearing pass is needed
// a held result stalls the lookup stage, which then holds the request side
// SETS must be a power of two
module set_assoc_tlb_lru_top #(
    parameter int SETS             = satlb_pkg::SETS_DEF,
    parameter int WAYS             = satlb_pkg::WAYS_DEF,
    parameter int PAGE_OFFSET_BITS = satlb_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int VA_BITS          = satlb_pkg::VA_BITS_DEF,
    parameter int RANK_W           = $clog2(WAYS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [VA_BITS-1:0]              i_virt_addr,
    input  logic [satlb_pkg::PA_BITS-1:0]   i_walk_page_base,
    input  logic                            i_walk_fault,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_status,
    output logic [satlb_pkg::PA_BITS-1:0]   o_phys_addr,
    output logic [RANK_W-1:0]               o_lru_rank
);

    localparam int POB   = PAGE_OFFSET_BITS;
    localparam int SET_W = $clog2(SETS);
    localparam int TAG_W = VA_BITS - POB - SET_W;
    localparam int PB_W  = satlb_pkg::PA_BITS - POB;
    localparam int ROW_W = WAYS * (TAG_W + PB_W + RANK_W);

    // lookup stage registers
    logic                           r_s1_valid;
    logic [1:0]                     r_op;
    logic [VA_BITS-1:0]             r_va;
    logic [satlb_pkg::PA_BITS-1:0]  r_wbase;
    logic                           r_fault;

    // result registers
    logic                           r_out_valid;
    satlb_pkg::t_status             r_status;
    logic [satlb_pkg::PA_BITS-1:0]  r_phys;
    logic [RANK_W-1:0]              r_rank;

    logic                           in_acc;
    logic                           s1_adv;
    logic [SET_W-1:0]               s1_set;
    logic [TAG_W-1:0]               s1_tag;
    logic [ROW_W-1:0]               rd_row;
    logic [ROW_W-1:0]               wr_row;
    logic [WAYS-1:0]                rd_valid;
    logic [WAYS-1:0][TAG_W-1:0]     rd_tags;
    logic [WAYS-1:0][PB_W-1:0]      rd_bases;
    logic [WAYS-1:0][RANK_W-1:0]    rd_ranks;
    logic [WAYS-1:0][TAG_W-1:0]     nx_tags;
    logic [WAYS-1:0][PB_W-1:0]      nx_bases;
    logic [WAYS-1:0][RANK_W-1:0]    nx_ranks;
    logic [WAYS-1:0]                valid_set;
    satlb_pkg::t_upd                upd;
    satlb_pkg::t_upd                wr;
    satlb_pkg::t_status             lk_status;
    logic [satlb_pkg::PA_BITS-1:0]  lk_phys;
    logic [RANK_W-1:0]              lk_rank;

    // handshakes
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // lookup stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_op;
            r_va    <= i_virt_addr;
            r_wbase <= i_walk_page_base;
            r_fault <= i_walk_fault;
        end
    end

    // address split
    assign s1_set = r_va[POB +: SET_W];
    assign s1_tag = r_va[VA_BITS-1 -: TAG_W];

    // state changes only when the item moves on
    assign wr.row_we    = upd.row_we && s1_adv;
    assign wr.clear_all = upd.clear_all && s1_adv;

    assign {rd_tags, rd_bases, rd_ranks} = rd_row;
    assign wr_row = {nx_tags, nx_bases, nx_ranks};

    satlb_store #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .ROW_W (ROW_W),
        .SET_W (SET_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_set    (i_virt_addr[POB +: SET_W]),
        .i_wr        (wr),
        .i_wr_set    (s1_set),
        .i_valid_set (valid_set),
        .i_wr_row    (wr_row),
        .o_row       (rd_row),
        .o_valid     (rd_valid)
    );

    satlb_lookup #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .POB    (POB),
        .PB_W   (PB_W),
        .RANK_W (RANK_W)
    ) u_lookup (
        .i_op        (satlb_pkg::t_op'(r_op)),
        .i_fault     (r_fault),
        .i_tag       (s1_tag),
        .i_offset    (r_va[POB-1:0]),
        .i_walk_base (r_wbase),
        .i_valid     (rd_valid),
        .i_tags      (rd_tags),
        .i_bases     (rd_bases),
        .i_ranks     (rd_ranks),
        .o_status    (lk_status),
        .o_phys      (lk_phys),
        .o_rank      (lk_rank),
        .o_upd       (upd),
        .o_valid_set (valid_set),
        .o_tags      (nx_tags),
        .o_bases     (nx_bases),
        .o_ranks     (nx_ranks)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_status <= lk_status;
            r_phys   <= lk_phys;
            r_rank   <= lk_rank;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_phys_addr = r_phys;
    assign o_lru_rank  = r_rank;

    // a stalled lookup keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_va) && $stable(r_op))
        else $error("lookup stage lost its item while stalled");

    // an install marks exactly one way valid
    a_fill_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && upd.row_we && r_op == satlb_pkg::OP_FILL |-> $onehot(valid_set))
        else $error("fill does not target exactly one way");

    // physical address only on hit or fill
    a_phys_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != satlb_pkg::ST_HIT && r_status != satlb_pkg::ST_FILLED
        |-> r_phys == '0)
        else $error("physical address on a result without translation");

    // rank only reported by a peek
    a_rank_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rank != '0 |-> r_status == satlb_pkg::ST_PEEKED)
        else $error("lru rank reported outside a peek");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for the set-associative tlb with lru ranks
// directed table then random items, results checked against typed table entries or a shadow copy of the tlb
// depends on satlb_pkg and set_assoc_tlb_lru_top
module tb;

    localparam int NSETS        = satlb_pkg::SETS_DEF;
    localparam int NWAYS        = satlb_pkg::WAYS_DEF;
    localparam int OFFB         = satlb_pkg::PAGE_OFFSET_BITS_DEF;
    localparam int VAB          = satlb_pkg::VA_BITS_DEF;
    localparam int PAB          = satlb_pkg::PA_BITS;
    localparam int SET_BITS     = $clog2(NSETS);
    localparam int VTAG_W       = VAB - OFFB - SET_BITS;
    localparam int PBASE_BITS   = PAB - OFFB;
    localparam int RANDOM_ITEMS = 1625;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CLK_HALF     = 2;

    localparam logic [VAB-1:0] VA_MAX = '1;
    localparam logic [PAB-1:0] PA_MAX = '1;

    typedef struct packed {
        satlb_pkg::t_status status;
        logic [PAB-1:0]     phys;
        logic [2:0]         rank;
    } t_tlb_result;

    typedef struct packed {
        satlb_pkg::t_op     op;
        logic [VAB-1:0]     va;
        logic [PAB-1:0]     wpb;
        logic               fault;
        logic               typed;
        t_tlb_result        res;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic [VAB-1:0]     i_virt_addr;
    logic [PAB-1:0]     i_walk_page_base;
    logic               i_walk_fault;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [2:0]         o_status;
    logic [PAB-1:0]     o_phys_addr;
    logic [2:0]         o_lru_rank;

    // typed expectation travels with a directed item
    logic        dir_typed;
    t_tlb_result dir_result;

    // shadow copy of the tlb contents
    logic                  shadow_valid [NSETS*NWAYS];
    logic [VTAG_W-1:0]     shadow_tag   [NSETS*NWAYS];
    logic [PBASE_BITS-1:0] shadow_base  [NSETS*NWAYS];
    logic [2:0]            shadow_rank  [NSETS*NWAYS];

    t_tlb_result pending_results[$];
    t_tlb_result predicted;
    t_tlb_result oldest;
    t_dir_row    dir_rows[$];
    int          errors;
    int          stall_cycles;
    bit          src_gaps_on;

    set_assoc_tlb_lru_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_virt_addr      (i_virt_addr),
        .i_walk_page_base (i_walk_page_base),
        .i_walk_fault     (i_walk_fault),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_phys_addr      (o_phys_addr),
        .o_lru_rank       (o_lru_rank)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void clear_shadow();
        int e;
        for (e = 0; e < NSETS*NWAYS; e++) begin
            shadow_valid[e] = 1'b0;
            shadow_tag[e]   = '0;
            shadow_base[e]  = '0;
            shadow_rank[e]  = 3'd0;
        end
    endfunction

    // way holding the tag in this set, or -1
    function automatic int find_way(int set, logic [VTAG_W-1:0] tag);
        int w;
        int hit_way;
        hit_way = -1;
        for (w = NWAYS-1; w >= 0; w--)
            if (shadow_valid[set*NWAYS+w] && shadow_tag[set*NWAYS+w] == tag)
                hit_way = w;
        return hit_way;
    endfunction

    // make a way most recent; an invalid way counts as older than all
    function automatic void make_recent(int set, int way);
        int       base;
        int       i;
        logic [2:0] old_rank;
        base     = set * NWAYS;
        old_rank = shadow_valid[base+way] ? shadow_rank[base+way] : 3'd0;
        for (i = 0; i < NWAYS; i++)
            if (i != way && shadow_valid[base+i] &&
                (old_rank == 3'd0 || shadow_rank[base+i] < old_rank))
                shadow_rank[base+i] = shadow_rank[base+i] + 3'd1;
        shadow_rank[base+way] = 3'd1;
    endfunction

    // expected result of one request, updating the shadow copy
    function automatic t_tlb_result tlb_predict(satlb_pkg::t_op op, logic [VAB-1:0] va,
                                                logic [PAB-1:0] wpb, logic fault);
        logic [VAB-OFFB-1:0] vpn;
        logic [VTAG_W-1:0]   tag;
        logic [OFFB-1:0]     offset;
        int                  set;
        int                  way;
        int                  e;
        int                  i;
        t_tlb_result         res;
        vpn    = va[VAB-1:OFFB];
        set    = int'(vpn[SET_BITS-1:0]);
        tag    = vpn[VAB-OFFB-1:SET_BITS];
        offset = va[OFFB-1:0];
        res    = '0;
        case (op)
            satlb_pkg::OP_TRANSLATE: begin
                way = find_way(set, tag);
                if (way >= 0) begin
                    res.phys   = {shadow_base[set*NWAYS+way], offset};
                    res.status = satlb_pkg::ST_HIT;
                    make_recent(set, way);
                end else begin
                    res.status = satlb_pkg::ST_MISS;
                end
            end
            satlb_pkg::OP_FILL: begin
                if (fault) begin
                    res.status = satlb_pkg::ST_FAULT;
                end else begin
                    way = find_way(set, tag);
                    // first free way, else the least recent one
                    if (way < 0) begin
                        for (i = NWAYS-1; i >= 0; i--)
                            if (!shadow_valid[set*NWAYS+i])
                                way = i;
                    end
                    if (way < 0) begin
                        way = 0;
                        for (i = 1; i < NWAYS; i++)
                            if (shadow_rank[set*NWAYS+i] > shadow_rank[set*NWAYS+way])
                                way = i;
                    end
                    make_recent(set, way);
                    e = set*NWAYS + way;
                    shadow_valid[e] = 1'b1;
                    shadow_tag[e]   = tag;
                    shadow_base[e]  = wpb[PAB-1:OFFB];
                    res.phys   = {shadow_base[e], offset};
                    res.status = satlb_pkg::ST_FILLED;
                end
            end
            satlb_pkg::OP_PEEK: begin
                way = find_way(set, tag);
                if (way >= 0)
                    res.rank = shadow_rank[set*NWAYS+way];
                res.status = satlb_pkg::ST_PEEKED;
            end
            default: begin
                clear_shadow();
                res.status = satlb_pkg::ST_CLEARED;
            end
        endcase
        return res;
    endfunction

    function automatic logic [VAB-1:0] va_of(logic [VTAG_W-1:0] tag,
                                             logic [SET_BITS-1:0] set, logic [OFFB-1:0] off);
        return {tag, set, off};
    endfunction

    function automatic t_dir_row row(satlb_pkg::t_op op, logic [VAB-1:0] va,
                                     logic [PAB-1:0] wpb, logic fault, logic typed,
                                     satlb_pkg::t_status st, logic [PAB-1:0] phys,
                                     logic [2:0] rank);
        t_dir_row r;
        r.op         = op;
        r.va         = va;
        r.wpb        = wpb;
        r.fault      = fault;
        r.typed      = typed;
        r.res.status = st;
        r.res.phys   = phys;
        r.res.rank   = rank;
        return r;
    endfunction

    // offer one request item after a random gap, return once it is taken
    task automatic offer_item(satlb_pkg::t_op op, logic [VAB-1:0] va, logic [PAB-1:0] wpb,
                              logic fault, logic typed, t_tlb_result res);
        int gap;
        gap = src_gaps_on ? int'($urandom_range(0, 4)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= op;
        i_virt_addr      <= va;
        i_walk_page_base <= wpb;
        i_walk_fault     <= fault;
        dir_typed        <= typed;
        dir_result       <= res;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // predict accepted requests, then check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predicted = tlb_predict(satlb_pkg::t_op'(i_op), i_virt_addr, i_walk_page_base,
                                    i_walk_fault);
            pending_results.push_back(dir_typed ? dir_result : predicted);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d phys %h rank %0d",
                         $time, o_status, o_phys_addr, o_lru_rank);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_status !== oldest.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, o_status);
                    errors++;
                end
                if (o_phys_addr !== oldest.phys) begin
                    $display("%0t: phys_addr expected %h actual %h",
                             $time, oldest.phys, o_phys_addr);
                    errors++;
                end
                if (o_lru_rank !== oldest.rank) begin
                    $display("%0t: lru_rank expected %0d actual %0d",
                             $time, oldest.rank, o_lru_rank);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches and one long hold
    initial begin : result_sink
        int gap;
        int taken;
        bit gaps_on;
        i_out_ready = 1'b0;
        taken       = 0;
        gaps_on     = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (taken % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
            // long hold so the pipeline fills and stalls the request side
            if (taken == 600)
                gap = LONG_HOLD;
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    // request side: reset, directed table, random items, drain
    initial begin : request_source
        logic [VTAG_W-1:0]   tag_pool [6];
        logic [VAB-1:0]      va;
        logic [VAB-1:0]      last_va;
        logic [PAB-1:0]      wpb;
        logic [63:0]         rnd64;
        logic                fault;
        satlb_pkg::t_op      op;
        int                  pick;
        int                  set;
        int                  n;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_op             = satlb_pkg::OP_TRANSLATE;
        i_virt_addr      = '0;
        i_walk_page_base = '0;
        i_walk_fault     = 1'b0;
        dir_typed        = 1'b0;
        dir_result       = '0;
        errors           = 0;
        src_gaps_on      = 1'b1;
        last_va          = '0;
        clear_shadow();

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (n = 2; n < 6; n++)
            tag_pool[n] = VTAG_W'($urandom);

        // empty tlb, fault, fill at the extremes
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, '0, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_MISS, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, '0, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_PEEKED, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, VA_MAX, PA_MAX, 1'b1, 1'b1,
                               satlb_pkg::ST_FAULT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_MISS, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, VA_MAX, PA_MAX, 1'b0, 1'b1,
                               satlb_pkg::ST_FILLED, PA_MAX, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_HIT, PA_MAX, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_PEEKED, '0, 3'd1));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, '0, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_FILLED, '0, 3'd0));
        // fill set 0 to capacity, low walk bits are ignored
        dir_rows.push_back(row(satlb_pkg::OP_FILL, va_of(1, '0, 12'h123), 48'h0000_1234_5FFF,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, va_of(2, '0, 12'hABC), 48'hA5A5_A5A5_A000,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, va_of(3, '0, 12'h001), 48'h5A5A_5A5A_5000,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        // hit ages the younger ways, then a fill replaces the least recent
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, va_of(0, '0, 12'hFFF), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, va_of(4, '0, 12'h010), 48'h7777_7777_7000,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, va_of(1, '0, 12'h000), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, va_of(1, '0, 12'h000), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        // refill of a present page rewrites it in place
        dir_rows.push_back(row(satlb_pkg::OP_FILL, va_of(2, '0, 12'h800), 48'hFEDC_BA98_7000,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, va_of(2, '0, 12'h000), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, va_of(3, '0, 12'h000), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, '0, 48'h1234_5678_9000, 1'b1, 1'b1,
                               satlb_pkg::ST_FAULT, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, va_of('1, '0, 12'h000), '0,
                               1'b0, 1'b0, satlb_pkg::ST_HIT, '0, 3'd0));
        // clear drops everything
        dir_rows.push_back(row(satlb_pkg::OP_CLEAR, '0, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_CLEARED, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, '0, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_MISS, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_PEEK, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_PEEKED, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_TRANSLATE, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_MISS, '0, 3'd0));
        dir_rows.push_back(row(satlb_pkg::OP_FILL, VA_MAX, '0, 1'b0, 1'b1,
                               satlb_pkg::ST_FILLED, 48'hFFF, 3'd0));

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (n = 0; n < dir_rows.size(); n++)
            offer_item(dir_rows[n].op, dir_rows[n].va, dir_rows[n].wpb, dir_rows[n].fault,
                       dir_rows[n].typed, dir_rows[n].res);

        // random items, mostly on a few sets and a small tag pool to force evictions
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                src_gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = satlb_pkg::OP_TRANSLATE;
            else if (pick < 80)
                op = satlb_pkg::OP_FILL;
            else if (pick < 97)
                op = satlb_pkg::OP_PEEK;
            else
                op = satlb_pkg::OP_CLEAR;
            rnd64 = {$urandom, $urandom};
            wpb   = rnd64[PAB-1:0];
            fault = ($urandom_range(0, 9) == 0);
            if (op == satlb_pkg::OP_FILL && $urandom_range(0, 9) < 6) begin
                // walk result for the last translate
                va = last_va;
            end else if ($urandom_range(0, 99) < 15) begin
                rnd64 = {$urandom, $urandom};
                va    = rnd64[VAB-1:0];
            end else begin
                set = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 2))
                                                 : int'($urandom_range(0, NSETS-1));
                va  = va_of(tag_pool[$urandom_range(0, 5)], SET_BITS'(set), OFFB'($urandom));
            end
            if (op == satlb_pkg::OP_TRANSLATE)
                last_va = va;
            offer_item(op, va, wpb, fault, 1'b0, '0);
        end

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
